FILE: hdl/sfq_pkg.sv
// Shared types, widths and codes of the search frontier queue.
// Used by every module of the block but sfq_ram; depends on nothing else.
`timescale 1ns / 1ps

package sfq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = PTR_W + 1;

  localparam int KEY_W   = 16;
  localparam int ENTRY_W = 3 * KEY_W;
  localparam int OCC_W   = 7;
  localparam int STAT_W  = 2;
  localparam int MODE_W  = 2;
  localparam int IN_DATA_W  = ENTRY_W;
  localparam int OUT_DATA_W = ((ENTRY_W + OCC_W + 7) / 8) * 8;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Insert mode codes; the unused code inserts at the back
  localparam logic [MODE_W-1:0] MODE_BACK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FRONT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SORTED = 2'd2;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // Write address selects
  localparam logic [1:0] WR_IDX   = 2'd0;
  localparam logic [1:0] WR_BACK  = 2'd1;
  localparam logic [1:0] WR_FRONT = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] tag;
    logic [KEY_W-1:0] h;
    logic [KEY_W-1:0] f;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic              latch;
    logic              idx_clr;
    logic              idx_inc;
    logic              wr_en;
    logic [1:0]        wr_sel;
    logic              carry_ld;
    logic              found_set;
    logic              head_inc;
    logic              head_dec;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              code_ld;
    logic [STAT_W-1:0] code;
    logic              res_ld;
  } sfq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic              op_pop;
    logic              empty;
    logic              full;
    logic [MODE_W-1:0] mode;
    logic              shift;
    logic              last;
    logic              out_free;
  } sfq_sts_t;

endpackage

FILE: hdl/search_frontier_queue.sv
// Top level of the search frontier queue: controller plus datapath.
// Uses sfq_pkg, sfq_ctrl, sfq_dpath.
`timescale 1ns / 1ps

// Bounded search frontier of QUEUE_DEPTH entries (f, h, tag).
// Input stream: tuser selects insert or pop, tdata carries f, h and tag.
// Output stream: one result per command; tuser is the status (ok, full,
// empty), tdata holds the popped entry (zero on inserts and failures) and
// the occupancy after the operation.
// Configuration: cfg_data_i is the insert mode (back, front, sorted by f
// then h); the write is always taken; change it only while idle.
// Timing: one command at a time. A sorted insert into a nonempty queue walks
// the ring buffer in RAM one entry a cycle, comparing keys and moving later
// entries up through the single write port. Reset empties the queue and sets
// the mode to back insert; RAM contents are not cleared. A stalled receiver
// holds the result register; the block then finishes the next command and
// waits for the register to free.
module search_frontier_queue
  import sfq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key_f, key_h, entry_tag
  input  logic                  s_axis_tuser,   // command
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_f, out_h, out_tag, occupancy
  output logic [STAT_W-1:0]     m_axis_tuser,   // status
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [MODE_W-1:0]     cfg_data_i     // insert_mode
);

  sfq_cmd_t cmd;
  sfq_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

FILE: hdl/sfq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module sfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/sfq_dpath.sv
// Datapath of the search frontier queue: ring buffer pointers, entry RAM,
// sorted-insert carry register, mode register and result register. Uses sfq_pkg, sfq_ram.
`timescale 1ns / 1ps

module sfq_dpath
  import sfq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  in_user_i,
  input  logic                  cfg_valid_i,
  input  logic [MODE_W-1:0]     cfg_data_i,
  input  sfq_cmd_t              cmd_i,
  output sfq_sts_t              sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic [STAT_W-1:0]     out_user_o
);

  function automatic logic [PTR_W-1:0] ring_addr(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  logic [MODE_W-1:0] mode_q;
  logic              op_pop_q;
  entry_t            new_q, carry_q, out_entry_q;
  logic [CNT_W-1:0]  idx_q, idx_d, count_q;
  logic [PTR_W-1:0]  head_q, head_prev, rd_addr, wr_addr;
  logic              found_q;
  logic [STAT_W-1:0] code_q, out_code_q;
  logic              out_valid_q;
  logic [OCC_W-1:0]  out_occ_q;
  entry_t            rd_entry;
  logic              old_lt;

  assign head_prev = (head_q == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_q - PTR_W'(1);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  assign rd_addr = ring_addr(head_q, idx_d);

  always_comb begin
    case (cmd_i.wr_sel)
      WR_BACK:  wr_addr = ring_addr(head_q, count_q);
      WR_FRONT: wr_addr = head_prev;
      default:  wr_addr = ring_addr(head_q, idx_q);
    endcase
  end

  sfq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (carry_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  // Stored entry stays ahead of the new one while its keys are strictly smaller
  assign old_lt = (rd_entry.f < new_q.f) || ((rd_entry.f == new_q.f) && (rd_entry.h < new_q.h));

  assign sts_o.op_pop   = (op_pop_q == CMD_POP);
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign sts_o.mode     = mode_q;
  assign sts_o.shift    = found_q | ~old_lt;
  assign sts_o.last     = ((idx_q + CNT_W'(1)) == count_q);
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_BACK;
      idx_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      idx_q <= idx_d;
      if (cmd_i.latch) begin
        found_q <= 1'b0;
      end else if (cmd_i.found_set) begin
        found_q <= 1'b1;
      end
      if (cmd_i.head_inc) begin
        head_q <= ring_addr(head_q, CNT_W'(1));
      end else if (cmd_i.head_dec) begin
        head_q <= head_prev;
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.res_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_pop_q <= in_user_i;
      new_q    <= in_data_i;
      carry_q  <= in_data_i;
    end else if (cmd_i.carry_ld) begin
      carry_q  <= rd_entry;
    end
    if (cmd_i.code_ld) begin
      code_q <= cmd_i.code;
    end
    if (cmd_i.res_ld) begin
      out_code_q  <= code_q;
      out_occ_q   <= OCC_W'(count_q);
      out_entry_q <= (op_pop_q == CMD_POP && code_q == STAT_OK) ? carry_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_code_q;
  assign out_data_o  = OUT_DATA_W'({out_occ_q, out_entry_q});

endmodule

FILE: hdl/sfq_ctrl.sv
// Controller of the search frontier queue: sequences insert, pop and the
// sorted-insert scan over the entry RAM. Uses sfq_pkg.
`timescale 1ns / 1ps

module sfq_ctrl
  import sfq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sfq_sts_t sts_i,
  output sfq_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_POPW   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_TAIL   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.code = STAT_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.code_ld = 1'b1;
        if (sts_i.op_pop) begin
          if (sts_i.empty) begin
            cmd_o.code = STAT_EMPTY;
            state_d    = S_FIN;
          end else begin
            cmd_o.idx_clr = 1'b1;
            state_d       = S_POPW;
          end
        end else if (sts_i.full) begin
          cmd_o.code = STAT_FULL;
          state_d    = S_FIN;
        end else begin
          unique case (sts_i.mode)
            MODE_FRONT: begin
              cmd_o.wr_en    = 1'b1;
              cmd_o.wr_sel   = WR_FRONT;
              cmd_o.head_dec = 1'b1;
              cmd_o.cnt_inc  = 1'b1;
              state_d        = S_FIN;
            end
            MODE_SORTED: begin
              if (sts_i.empty) begin
                cmd_o.wr_en   = 1'b1;
                cmd_o.wr_sel  = WR_BACK;
                cmd_o.cnt_inc = 1'b1;
                state_d       = S_FIN;
              end else begin
                cmd_o.idx_clr = 1'b1;
                state_d       = S_SCAN;
              end
            end
            default: begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = WR_BACK;
              cmd_o.cnt_inc = 1'b1;
              state_d       = S_FIN;
            end
          endcase
        end
      end
      S_POPW: begin
        cmd_o.carry_ld = 1'b1;
        cmd_o.head_inc = 1'b1;
        cmd_o.cnt_dec  = 1'b1;
        state_d        = S_FIN;
      end
      S_SCAN: begin
        // Once the slot is found, write the carried entry and carry the old one up
        if (sts_i.shift) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_sel    = WR_IDX;
          cmd_o.carry_ld  = 1'b1;
          cmd_o.found_set = 1'b1;
        end
        if (sts_i.last) begin
          state_d = S_TAIL;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_TAIL: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_BACK;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        // Hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/sfq_checker.sv
// Port-level checks of the search frontier queue, bound to the top level.
// Uses sfq_pkg.
`timescale 1ns / 1ps

module sfq_checker
  import sfq_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STAT_W-1:0]     m_axis_tuser,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [MODE_W-1:0]     cfg_data_i
);

  logic [OCC_W-1:0] occ;
  assign occ = m_axis_tdata[ENTRY_W +: OCC_W];

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Empty pop reports nothing held and no entry
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_EMPTY |-> m_axis_tdata == '0)
    else $error("empty pop with nonzero data");

  // Full drop reports a full store
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_FULL |->
      occ == OCC_W'(QUEUE_DEPTH) && m_axis_tdata[ENTRY_W-1:0] == '0)
    else $error("full status with wrong occupancy or data");

  // No command is taken back to back with the one before it
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command taken back to back");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == STAT_OK || m_axis_tuser == STAT_FULL
      || m_axis_tuser == STAT_EMPTY)
    else $error("undefined status code");

endmodule

bind search_frontier_queue sfq_checker u_sfq_checker (.*);

FILE: bench/search_frontier_queue_tb.sv
// Self-checking bench for search_frontier_queue: directed and random insert/pop traffic
// in every insert mode, checked against a behavioral frontier model.
// Depends on sfq_pkg and the search_frontier_queue RTL.
`timescale 1ns / 1ps

module search_frontier_queue_tb
  import sfq_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 100;
  // Mode code with no defined use; inserts go at the back
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  f;
    logic [KEY_W-1:0]  h;
    logic [KEY_W-1:0]  tag;
    logic [OCC_W-1:0]  occ;
  } result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = CMD_INSERT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [MODE_W-1:0]     cfg_data_i = MODE_BACK;

  // Frontier model state
  entry_t            frontier_model[QUEUE_DEPTH];
  int                model_count = 0;
  logic [MODE_W-1:0] model_mode = MODE_BACK;
  result_t           pending_results[$];

  int err_count = 0;
  int cycle_count = 0;
  int traffic_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  search_frontier_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < PRINT_LIMIT)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[15:0] !== want.f) report_mismatch("out_f", m_axis_tdata[15:0], want.f);
        if (m_axis_tdata[31:16] !== want.h) report_mismatch("out_h", m_axis_tdata[31:16], want.h);
        if (m_axis_tdata[47:32] !== want.tag)
          report_mismatch("out_tag", m_axis_tdata[47:32], want.tag);
        if (m_axis_tdata[54:48] !== want.occ)
          report_mismatch("occupancy", m_axis_tdata[54:48], want.occ);
      end
    end
  end

  // Apply one accepted command to the frontier model and queue its result
  task automatic predict_frontier(input logic cmd, input entry_t item);
    result_t r;
    int pos;
    int i;
    r = '0;
    if (cmd == CMD_INSERT) begin
      if (model_count >= QUEUE_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        if (model_mode == MODE_FRONT) begin
          pos = 0;
        end else if (model_mode == MODE_SORTED) begin
          pos = 0;
          while (pos < model_count && (frontier_model[pos].f < item.f ||
                 (frontier_model[pos].f == item.f && frontier_model[pos].h < item.h)))
            pos++;
        end else begin
          pos = model_count;
        end
        for (i = model_count; i > pos; i--) frontier_model[i] = frontier_model[i-1];
        frontier_model[pos] = item;
        model_count++;
        r.status = STAT_OK;
      end
    end else begin
      if (model_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.status = STAT_OK;
        r.f      = frontier_model[0].f;
        r.h      = frontier_model[0].h;
        r.tag    = frontier_model[0].tag;
        for (i = 1; i < model_count; i++) frontier_model[i-1] = frontier_model[i];
        model_count--;
      end
    end
    r.occ = model_count[OCC_W-1:0];
    pending_results.push_back(r);
  endtask

  task automatic send_command(input logic cmd, input logic [KEY_W-1:0] f,
                              input logic [KEY_W-1:0] h, input logic [KEY_W-1:0] tag);
    entry_t item;
    item.f   = f;
    item.h   = h;
    item.tag = tag;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= item;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frontier(cmd, item);
    traffic_count++;
  endtask

  task automatic set_idle_phase(input int phase);
    case (phase)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
      default: begin src_idle_pct = 38; sink_stall_pct = 38; end
    endcase
  endtask

  // Hold the input low until every expected result is back
  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_insert_mode(input logic [MODE_W-1:0] mode);
    wait_for_idle();
    cfg_data_i  <= mode;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model_mode = mode;
  endtask

  // Bias keys toward extremes and a tiny range so sorted ties are common
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return KEY_W'($urandom_range(3));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  task automatic send_random(input int insert_pct);
    logic cmd;
    cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_POP;
    set_idle_phase((traffic_count / 40) % 4);
    send_command(cmd, pick_key(), pick_key(), KEY_W'($urandom));
  endtask

  task automatic test_back_mode();
    // reset leaves the mode at back insert
    set_idle_phase(0);
    send_command(CMD_POP, 16'h1234, 16'h5678, 16'h9abc);
    send_command(CMD_INSERT, 16'h0000, 16'h0000, 16'h0000);
    send_command(CMD_INSERT, 16'hffff, 16'hffff, 16'hffff);
    send_command(CMD_INSERT, 16'haaaa, 16'h5555, 16'ha5a5);
    send_command(CMD_POP, 16'hffff, 16'hffff, 16'hffff);
    send_command(CMD_POP, 16'h0000, 16'h0000, 16'h0000);
    send_command(CMD_POP, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_front_mode();
    write_insert_mode(MODE_FRONT);
    set_idle_phase(1);
    send_command(CMD_INSERT, 16'h0001, 16'h0002, 16'h0003);
    send_command(CMD_INSERT, 16'h5555, 16'haaaa, 16'h5a5a);
    send_command(CMD_POP, 16'h0000, 16'h0000, 16'h0000);
    send_command(CMD_POP, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_sorted_mode();
    write_insert_mode(MODE_SORTED);
    set_idle_phase(2);
    send_command(CMD_INSERT, 16'h0010, 16'h0005, 16'h0001);
    send_command(CMD_INSERT, 16'hffff, 16'h0000, 16'h0002);
    send_command(CMD_INSERT, 16'h0010, 16'h0003, 16'h0003);
    // equal f and h: newest goes first
    send_command(CMD_INSERT, 16'h0010, 16'h0005, 16'h0004);
    send_command(CMD_INSERT, 16'h0000, 16'hffff, 16'h0005);
    send_command(CMD_INSERT, 16'h0010, 16'hffff, 16'h0006);
    set_idle_phase(3);
    repeat (6) send_command(CMD_POP, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_spare_mode();
    write_insert_mode(MODE_SPARE);
    set_idle_phase(3);
    send_command(CMD_INSERT, 16'h0002, 16'h0002, 16'hbeef);
    send_command(CMD_INSERT, 16'h0001, 16'h0001, 16'hcafe);
    send_command(CMD_POP, 16'h0000, 16'h0000, 16'h0000);
    send_command(CMD_POP, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // Fill past full, mix, then drain down to a floor (past empty at zero)
  task automatic run_frontier_segment(input logic [MODE_W-1:0] mode, input int floor_count);
    int refused;
    write_insert_mode(mode);
    refused = 0;
    while (refused < 3) begin
      if (model_count == QUEUE_DEPTH) refused++;
      send_random(90);
    end
    repeat (15) send_random(50);
    while (model_count > floor_count) send_random(10);
    if (floor_count == 0) begin
      send_random(0);
      send_random(0);
    end
  endtask

  task automatic test_random_traffic();
    run_frontier_segment(MODE_SORTED, 0);
    run_frontier_segment(MODE_BACK, 24);
    run_frontier_segment(MODE_FRONT, 0);
    run_frontier_segment(MODE_SPARE, 24);
    run_frontier_segment(MODE_SORTED, 0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_back_mode();
    test_front_mode();
    test_sorted_mode();
    test_spare_mode();
    test_random_traffic();
    wait_for_idle();
    repeat (80) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/sfq_pkg.sv
hdl/sfq_ram.sv
hdl/sfq_dpath.sv
hdl/sfq_ctrl.sv
hdl/search_frontier_queue.sv
hdl/sfq_checker.sv
bench/search_frontier_queue_tb.sv
